FILE: rtl/twa_pkg.sv
// Shared constants and types for the threshold window average filter.
`default_nettype none
package twa_pkg;

    localparam int TWA_MAX_WIDTH  = 1024;
    localparam int TWA_MAX_HEIGHT = 1024;
    localparam int TWA_MAX_RADIUS = 3;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMG_WIDTH  = 2'd0,
        CFG_IMG_HEIGHT = 2'd1,
        CFG_RADIUS     = 2'd2,
        CFG_THRESHOLD  = 2'd3
    } cfg_idx_t;

    // Input beat kinds
    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_type_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CWAIT,
        ST_SCAN,
        ST_DIVST,
        ST_DIV,
        ST_OUT
    } twa_state_t;

    // Divider handshake
    typedef struct packed {
        logic start;
    } div_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/threshold_window_average_top.sv
// Top level of the threshold window average filter: config, output stage, instances.
// A beat that releases an output runs through check with centre read, window scan, divider
// start, divide and output; other beats return to idle after the check. One beat at a time:
// the input is ready only in idle. The scan reads one line store entry per cycle and the
// divider makes one quotient bit per cycle over SUMW bits (14 at the default MAX_RADIUS of 3).
// Reset (aresetn, synchronous, low): config to defaults, positions to zero, no result.
`default_nettype none
module threshold_window_average_top #(
    parameter int MAX_WIDTH  = twa_pkg::TWA_MAX_WIDTH,
    parameter int MAX_HEIGHT = twa_pkg::TWA_MAX_HEIGHT,
    parameter int MAX_RADIUS = twa_pkg::TWA_MAX_RADIUS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [twa_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [twa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] pixel
    input  wire logic                        s_tuser,   // [0] req_type
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] filtered
    output logic                             m_tlast
);
    import twa_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH + 1);
    localparam int YW   = $clog2(MAX_HEIGHT + 1);
    localparam int RADW = $clog2(MAX_RADIUS + 1);
    localparam int AW   = $clog2(2 * MAX_RADIUS + 2) + $clog2(MAX_WIDTH);
    localparam int WINN = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SUMW = $clog2(WINN * 255 + 1);
    localparam int CNTW = $clog2(WINN + 1);

    logic [10:0] w_reg, h_reg;
    logic [1:0]  r_reg;
    logic [7:0]  thr_reg;
    logic [XW-1:0]   eff_w;
    logic [YW-1:0]   eff_h;
    logic [RADW-1:0] eff_r;
    logic geo_restart;

    logic m_tvalid_reg, m_tlast_reg;
    logic [7:0] m_tdata_reg;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata, mem_rdata;
    div_ctl_t        div_ctl;
    logic [SUMW-1:0] div_dividend;
    logic [CNTW-1:0] div_divisor;
    logic            div_done;
    logic [7:0]      div_quot;
    logic            o_free, o_load, o_last;
    logic [7:0]      o_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg   <= 11'd1024;
            h_reg   <= 11'd1024;
            r_reg   <= 2'd1;
            thr_reg <= 8'd16;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_IMG_WIDTH:  w_reg   <= cfg_wdata;
                CFG_IMG_HEIGHT: h_reg   <= cfg_wdata;
                CFG_RADIUS:     r_reg   <= cfg_wdata[1:0];
                CFG_THRESHOLD:  thr_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign geo_restart = cfg_we && (cfg_idx_t'(cfg_idx) != CFG_THRESHOLD);

    // Effective geometry, clamped to the supported range
    always_comb begin
        if (w_reg == '0) begin
            eff_w = XW'(1);
        end else if (int'(w_reg) > MAX_WIDTH) begin
            eff_w = XW'(MAX_WIDTH);
        end else begin
            eff_w = XW'(w_reg);
        end
        if (h_reg == '0) begin
            eff_h = YW'(1);
        end else if (int'(h_reg) > MAX_HEIGHT) begin
            eff_h = YW'(MAX_HEIGHT);
        end else begin
            eff_h = YW'(h_reg);
        end
        if (int'(r_reg) > MAX_RADIUS) begin
            eff_r = RADW'(MAX_RADIUS);
        end else begin
            eff_r = RADW'(r_reg);
        end
    end

    // Output register
    assign o_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (o_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            m_tdata_reg <= o_data;
            m_tlast_reg <= o_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    twa_line_mem #(.AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    twa_div #(.SUMW(SUMW), .CNTW(CNTW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    twa_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS),
        .XW (XW), .YW (YW), .RADW (RADW), .AW (AW), .SUMW (SUMW), .CNTW (CNTW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .eff_r        (eff_r),
        .thr          (thr_reg),
        .geo_restart  (geo_restart),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_req        (s_tuser),
        .s_pix        (s_tdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .div_ctl      (div_ctl),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .o_free       (o_free),
        .o_load       (o_load),
        .o_data       (o_data),
        .o_last       (o_last)
    );
endmodule
`default_nettype wire

FILE: rtl/twa_line_mem.sv
// Line store: synchronous RAM, one write and one registered read port.
`default_nettype none
module twa_line_mem #(
    parameter int AW = 13
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/twa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module twa_div #(
    parameter int SUMW = 14,
    parameter int CNTW = 6
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  twa_pkg::div_ctl_t    ctl,
    input  wire logic [SUMW-1:0] dividend,
    input  wire logic [CNTW-1:0] divisor,
    output logic                 done,
    output logic [7:0]           quotient
);
    import twa_pkg::*;

    localparam int ITW = $clog2(SUMW + 1);

    logic [SUMW-1:0] q_reg;
    logic [CNTW-1:0] rem_reg;
    logic [CNTW-1:0] dvs_reg;
    logic [ITW-1:0]  it_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [CNTW:0]   rem_sh;
    logic            qbit;

    // Trial subtract
    always_comb begin
        rem_sh = {rem_reg, q_reg[SUMW-1]};
        qbit   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                it_reg   <= ITW'(SUMW);
            end else if (busy_reg) begin
                it_reg <= it_reg - 1'b1;
                if (it_reg == ITW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[SUMW-2:0], qbit};
            rem_reg <= qbit ? CNTW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNTW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[7:0];
endmodule
`default_nettype wire

FILE: rtl/twa_ctrl.sv
// Sequencer: raster counters, window scan over the line store, accumulation.
`default_nettype none
module twa_ctrl #(
    parameter int MAX_WIDTH  = twa_pkg::TWA_MAX_WIDTH,
    parameter int MAX_HEIGHT = twa_pkg::TWA_MAX_HEIGHT,
    parameter int MAX_RADIUS = twa_pkg::TWA_MAX_RADIUS,
    parameter int XW   = $clog2(MAX_WIDTH + 1),
    parameter int YW   = $clog2(MAX_HEIGHT + 1),
    parameter int RADW = $clog2(MAX_RADIUS + 1),
    parameter int AW   = $clog2(2 * MAX_RADIUS + 2) + $clog2(MAX_WIDTH),
    parameter int SUMW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1),
    parameter int CNTW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [XW-1:0]   eff_w,
    input  wire logic [YW-1:0]   eff_h,
    input  wire logic [RADW-1:0] eff_r,
    input  wire logic [7:0]      thr,
    input  wire logic            geo_restart,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_req,
    input  wire logic [7:0]      s_pix,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [7:0]           mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    input  wire logic [7:0]      mem_rdata,
    output twa_pkg::div_ctl_t    div_ctl,
    output logic [SUMW-1:0]      div_dividend,
    output logic [CNTW-1:0]      div_divisor,
    input  wire logic            div_done,
    input  wire logic [7:0]      div_quot,
    input  wire logic            o_free,
    output logic                 o_load,
    output logic [7:0]           o_data,
    output logic                 o_last
);
    import twa_pkg::*;

    localparam int CAW = $clog2(MAX_WIDTH);
    localparam int SW  = AW - CAW;
    localparam int DW  = RADW + 1;

    twa_state_t state_reg, state_next;

    logic [YW-1:0] in_row_reg, out_row_reg, cr_reg;
    logic [XW-1:0] in_col_reg, out_col_reg, cc_reg;
    logic          fe_reg;
    logic [DW-1:0] dy_reg, dx_reg;
    logic          all_iss_reg;
    logic [7:0]    centre_reg;
    logic [SUMW-1:0] sum_reg;
    logic [CNTW-1:0] cnt_reg;

    logic accept, is_pix, frame_done;
    logic [YW-1:0] wr_row, row_inc;
    logic [XW-1:0] wr_col, col_inc;
    logic [YW:0]   need_row_s;
    logic [XW:0]   need_col_s;
    logic [YW-1:0] need_row;
    logic [XW-1:0] need_col;
    logic          ready_out;
    logic [DW-1:0] two_r;
    logic signed [YW+1:0] ys, hs;
    logic signed [XW+1:0] xs, ws;
    logic [YW-1:0] ry;
    logic [XW-1:0] rx;
    logic [7:0]    diff;
    logic          take;
    logic          issue, capture, acc;

    assign accept = s_valid && s_ready;
    assign is_pix = (req_type_t'(s_req) == REQ_PIXEL);
    assign frame_done = (in_row_reg >= eff_h);

    // Write position of an incoming pixel, restarting after a complete frame
    always_comb begin
        wr_row  = frame_done ? '0 : in_row_reg;
        wr_col  = frame_done ? '0 : in_col_reg;
        col_inc = wr_col + 1'b1;
        row_inc = wr_row + 1'b1;
    end

    // Readiness of the next output: its clamped window has fully arrived
    always_comb begin
        need_row_s = {1'b0, out_row_reg} + (YW+1)'(eff_r);
        need_col_s = {1'b0, out_col_reg} + (XW+1)'(eff_r);
        need_row   = (need_row_s > {1'b0, eff_h - 1'b1}) ? eff_h - 1'b1 : need_row_s[YW-1:0];
        need_col   = (need_col_s > {1'b0, eff_w - 1'b1}) ? eff_w - 1'b1 : need_col_s[XW-1:0];
        ready_out  = (out_row_reg < eff_h) &&
                     ((in_row_reg > need_row) ||
                      ((in_row_reg == need_row) && (in_col_reg > need_col)));
    end

    // Clamped window coordinate for the current scan position
    always_comb begin
        two_r = {eff_r, 1'b0};
        hs = $signed({2'b00, eff_h}) - 1;
        ws = $signed({2'b00, eff_w}) - 1;
        ys = $signed({2'b00, cr_reg}) + $signed((YW+2)'(dy_reg)) - $signed((YW+2)'(eff_r));
        xs = $signed({2'b00, cc_reg}) + $signed((XW+2)'(dx_reg)) - $signed((XW+2)'(eff_r));
        if (ys < 0) begin
            ry = '0;
        end else if (ys > hs) begin
            ry = eff_h - 1'b1;
        end else begin
            ry = ys[YW-1:0];
        end
        if (xs < 0) begin
            rx = '0;
        end else if (xs > ws) begin
            rx = eff_w - 1'b1;
        end else begin
            rx = xs[XW-1:0];
        end
    end

    // Threshold test on the returning read
    always_comb begin
        diff = (mem_rdata > centre_reg) ? mem_rdata - centre_reg : centre_reg - mem_rdata;
        take = (diff <= thr);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CHECK;
            ST_CHECK: state_next = ready_out ? ST_CWAIT : ST_IDLE;
            ST_CWAIT: state_next = ST_SCAN;
            ST_SCAN:  if (all_iss_reg) state_next = ST_DIVST;
            ST_DIVST: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (o_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs and strobes
    always_comb begin
        s_ready       = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = {ry[SW-1:0], rx[CAW-1:0]};
        issue         = 1'b0;
        capture       = 1'b0;
        acc           = 1'b0;
        div_ctl.start = 1'b0;
        o_load        = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_CHECK: begin
                mem_re    = ready_out;
                mem_raddr = {out_row_reg[SW-1:0], out_col_reg[CAW-1:0]};
            end
            ST_CWAIT: begin
                mem_re  = 1'b1;
                issue   = 1'b1;
                capture = 1'b1;
            end
            ST_SCAN: begin
                acc    = 1'b1;
                mem_re = !all_iss_reg;
                issue  = !all_iss_reg;
            end
            ST_DIVST: div_ctl.start = 1'b1;
            ST_OUT:   o_load = o_free;
            default: ;
        endcase
    end

    assign mem_we    = accept && is_pix;
    assign mem_waddr = {wr_row[SW-1:0], wr_col[CAW-1:0]};
    assign mem_wdata = s_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn || geo_restart) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            if (mem_we) begin
                if (frame_done) begin
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                if (col_inc >= eff_w) begin
                    in_col_reg <= '0;
                    in_row_reg <= row_inc;
                end else begin
                    in_col_reg <= col_inc;
                    in_row_reg <= wr_row;
                end
            end
            if (state_reg == ST_CHECK && ready_out) begin
                if (out_col_reg + 1'b1 >= eff_w) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // Window scan datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            cr_reg      <= out_row_reg;
            cc_reg      <= out_col_reg;
            fe_reg      <= (out_row_reg == eff_h - 1'b1) && (out_col_reg == eff_w - 1'b1);
            dy_reg      <= '0;
            dx_reg      <= '0;
            all_iss_reg <= 1'b0;
        end
        if (capture) begin
            centre_reg <= mem_rdata;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        if (issue) begin
            if (dx_reg == two_r) begin
                dx_reg <= '0;
                if (dy_reg == two_r) begin
                    all_iss_reg <= 1'b1;
                end else begin
                    dy_reg <= dy_reg + 1'b1;
                end
            end else begin
                dx_reg <= dx_reg + 1'b1;
            end
        end
        if (acc && take) begin
            sum_reg <= sum_reg + SUMW'(mem_rdata);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign div_dividend = sum_reg;
    assign div_divisor  = cnt_reg;
    assign o_data       = div_quot;
    assign o_last       = fe_reg;
endmodule
`default_nettype wire
